>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the rtl checks, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/crse_pkg.sv
// ----------------------------------------------------------------------------
// crse_pkg
// types and fixed widths of the catmull-rom spline evaluator
// ----------------------------------------------------------------------------
package crse_pkg;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } t_cmd;

    localparam int IDX_W      = 5;
    localparam int KNOT_W     = 16;
    localparam int POS_W      = 24;
    localparam int CURVE_W    = 24;
    localparam int CNT_W      = 6;
    localparam int FRAC_W     = 16;
    localparam int P_W        = FRAC_W + 1;       // clamped position 0..1.0
    localparam int T_W        = FRAC_W + 1;       // span fraction 0..1.0
    localparam int S_W        = P_W + CNT_W;      // scaled position
    localparam int D3_W       = KNOT_W + 3;
    localparam int D2_W       = KNOT_W + 4;
    localparam int D1_W       = KNOT_W + 1;
    localparam int HI_W       = 22;               // accumulator above the fraction
    localparam int P1_W       = D3_W + T_W + 1;
    localparam int PH_W       = HI_W + T_W + 1;
    localparam int PL_W       = FRAC_W + T_W;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int MIN_KNOTS  = 4;

    localparam logic [P_W-1:0] P_ONE = P_W'(1) << FRAC_W;

endpackage

>>> hw/rtl/crse_ram.sv
// ----------------------------------------------------------------------------
// crse_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module crse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/catmull_rom_spline_eval.sv
// an accepted evaluate request reaches o_m_tvalid through each stage register in turn
// throughput: one request per clock unless a full pipeline waits on i_m_tready; load
// requests give no result and leave the pipeline after the knot ram write in stage 2
// the ten stage registers each hold one request and advance on their own valid/ready
// reset (i_rst_n low, synchronous) empties the pipeline and sets the knot count to 4;
// the knot table itself is not cleared
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval
// uniform catmull-rom spline over a knot table, horner evaluation, 10 stages
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module catmull_rom_spline_eval #(
    parameter int MAX_KNOTS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: knot count
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [crse_pkg::CNT_W-1:0]         i_cfg_data,
    // request stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // knot_index[4:0], knot_value[20:5], position[44:21], zero pad
    input  logic [crse_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // cmd[0]
    input  logic                               i_s_tuser,
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // curve_value[23:0]
    output logic [crse_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // too_few_knots[0]
    output logic                               o_m_tuser
);

    import crse_pkg::*;

    localparam int NSTG = 10;
    localparam int AW   = $clog2(MAX_KNOTS);
    localparam logic [8:0] MaxKnots9 = 9'(MAX_KNOTS);

    // ------------------------------------------------------------------------
    // configuration and stage control
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] r_knot_count;
    logic [CNT_W-1:0] n_eff;
    logic             few;
    logic [NSTG:1]    r_v;
    logic [NSTG:1]    en;

    assign o_cfg_ready = 1'b1;
    assign n_eff = ({3'b0, r_knot_count} > MaxKnots9) ? CNT_W'(MAX_KNOTS) : r_knot_count;
    assign few   = (n_eff < CNT_W'(MIN_KNOTS));

    always_comb begin
        en[NSTG] = !r_v[NSTG] || i_m_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_tready = en[1];

    // ------------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------------
    t_cmd                    r_s1_cmd, r_s2_cmd;
    logic [IDX_W-1:0]        r_s1_idx, r_s2_idx;
    logic [KNOT_W-1:0]       r_s1_val, r_s2_val;
    logic [P_W-1:0]          r_s1_p;
    logic [CNT_W-1:0]        r_s2_span;
    logic [T_W-1:0]          r_s2_t, r_s3_t, r_s4_t, r_s5_t, r_s6_t, r_s7_t, r_s8_t;
    logic signed [D3_W-1:0]  r_s4_d3;
    logic signed [D2_W-1:0]  r_s4_d2, r_s5_d2;
    logic signed [D1_W-1:0]  r_s4_d1, r_s5_d1, r_s6_d1, r_s7_d1;
    logic signed [D1_W-1:0]  r_s4_d0, r_s5_d0, r_s6_d0, r_s7_d0, r_s8_d0, r_s9_d0;
    logic signed [P1_W-1:0]  r_s5_p1;
    logic signed [HI_W-1:0]  r_s6_hi, r_s8_hi;
    logic [FRAC_W-1:0]       r_s6_lo, r_s8_lo;
    logic signed [PH_W-1:0]  r_s7_ph, r_s9_ph;
    logic [PL_W-1:0]         r_s7_pl, r_s9_pl;
    logic [CURVE_W-1:0]      r_s10_curve;
    logic                    r_s10_few;

    // ------------------------------------------------------------------------
    // stage 0: unpack and clamp position to 0..1
    // ------------------------------------------------------------------------
    logic signed [POS_W-1:0] in_pos;
    logic [P_W-1:0]          n_s1_p;

    assign in_pos = $signed(i_s_tdata[44:21]);

    always_comb begin
        if (in_pos < 0) begin
            n_s1_p = '0;
        end else if (in_pos > $signed(POS_W'(P_ONE))) begin
            n_s1_p = P_ONE;
        end else begin
            n_s1_p = in_pos[P_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: scale by span count, pick span and fraction
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] spans, span_cap, n_s2_span;
    logic [S_W-1:0]   scaled;
    logic [S_W-FRAC_W-1:0] span_raw;
    logic [T_W-1:0]   n_s2_t;

    assign spans    = n_eff - CNT_W'(3);
    assign span_cap = n_eff - CNT_W'(4);
    assign scaled   = S_W'(r_s1_p) * S_W'(spans);
    assign span_raw = scaled[S_W-1:FRAC_W];
    // the top position lands on the last span with a full fraction
    assign n_s2_span = (span_raw > {1'b0, span_cap}) ? span_cap : span_raw[CNT_W-1:0];
    assign n_s2_t    = T_W'(scaled - S_W'({n_s2_span, {FRAC_W{1'b0}}}));

    // ------------------------------------------------------------------------
    // stage 2: knot ram, one copy per neighbor, loads written in request order
    // ------------------------------------------------------------------------
    logic [KNOT_W-1:0] rd_knot [4];
    logic              knot_we;
    logic [AW-1:0]     knot_waddr;

    assign knot_we    = en[3] && r_v[2] && (r_s2_cmd == CMD_LOAD)
                        && ({4'b0, r_s2_idx} < MaxKnots9);
    assign knot_waddr = AW'({4'b0, r_s2_idx});

    for (genvar g = 0; g < 4; g++) begin : g_knot
        crse_ram #(
            .WIDTH (KNOT_W),
            .DEPTH (MAX_KNOTS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (knot_we),
            .i_waddr (knot_waddr),
            .i_wdata (r_s2_val),
            .i_re    (en[3]),
            .i_raddr (AW'({3'b0, r_s2_span} + 9'(g))),
            .o_rdata (rd_knot[g])
        );
    end

    // ------------------------------------------------------------------------
    // stage 3: doubled basis coefficients
    // ------------------------------------------------------------------------
    logic signed [D2_W-1:0] e0, e1, e2, e3, k12;
    logic signed [D3_W-1:0] n_s4_d3;
    logic signed [D2_W-1:0] n_s4_d2;
    logic signed [D1_W-1:0] n_s4_d1, n_s4_d0;

    assign e0  = D2_W'($signed(rd_knot[0]));
    assign e1  = D2_W'($signed(rd_knot[1]));
    assign e2  = D2_W'($signed(rd_knot[2]));
    assign e3  = D2_W'($signed(rd_knot[3]));
    assign k12 = e1 - e2;

    assign n_s4_d3 = D3_W'((k12 <<< 1) + k12 + e3 - e0);
    assign n_s4_d2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    assign n_s4_d1 = D1_W'(e2 - e0);
    assign n_s4_d0 = D1_W'(e1 <<< 1);

    // ------------------------------------------------------------------------
    // stages 4..10: horner, acc kept as high part and 16 fraction bits
    // ------------------------------------------------------------------------
    logic signed [P1_W-1:0] n_s5_p1;
    logic signed [HI_W-1:0] n_s6_hi, n_s8_hi, hi3;
    logic signed [PH_W-1:0] q2, q3;

    assign n_s5_p1 = r_s4_d3 * $signed({1'b0, r_s4_t});
    // low 16 bits of d2 << 16 are zero, so only the high part sees the add
    assign n_s6_hi = HI_W'($signed(r_s5_p1[P1_W-1:FRAC_W])) + HI_W'(r_s5_d2);
    assign q2      = r_s7_ph + PH_W'(r_s7_pl[PL_W-1:FRAC_W]);
    assign n_s8_hi = HI_W'(q2[PH_W-1:FRAC_W]) + HI_W'(r_s7_d1);
    assign q3      = r_s9_ph + PH_W'(r_s9_pl[PL_W-1:FRAC_W]);
    // plus one half lsb of the result, then drop the doubling
    assign hi3     = HI_W'(q3[PH_W-1:FRAC_W]) + HI_W'(r_s9_d0) + HI_W'(1);

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= CNT_W'(MIN_KNOTS);
            r_v          <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_knot_count <= i_cfg_data;
            end
            if (en[1]) r_v[1] <= i_s_tvalid;
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2] && (r_s2_cmd == CMD_EVAL);
            for (int k = 4; k <= NSTG; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_cmd <= t_cmd'(i_s_tuser);
            r_s1_idx <= i_s_tdata[4:0];
            r_s1_val <= i_s_tdata[20:5];
            r_s1_p   <= n_s1_p;
        end
        if (en[2]) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_idx  <= r_s1_idx;
            r_s2_val  <= r_s1_val;
            r_s2_span <= n_s2_span;
            r_s2_t    <= n_s2_t;
        end
        if (en[3]) begin
            r_s3_t <= r_s2_t;
        end
        if (en[4]) begin
            r_s4_d3 <= n_s4_d3;
            r_s4_d2 <= n_s4_d2;
            r_s4_d1 <= n_s4_d1;
            r_s4_d0 <= n_s4_d0;
            r_s4_t  <= r_s3_t;
        end
        if (en[5]) begin
            r_s5_p1 <= n_s5_p1;
            r_s5_d2 <= r_s4_d2;
            r_s5_d1 <= r_s4_d1;
            r_s5_d0 <= r_s4_d0;
            r_s5_t  <= r_s4_t;
        end
        if (en[6]) begin
            r_s6_hi <= n_s6_hi;
            r_s6_lo <= r_s5_p1[FRAC_W-1:0];
            r_s6_d1 <= r_s5_d1;
            r_s6_d0 <= r_s5_d0;
            r_s6_t  <= r_s5_t;
        end
        if (en[7]) begin
            r_s7_ph <= r_s6_hi * $signed({1'b0, r_s6_t});
            r_s7_pl <= PL_W'(r_s6_lo) * PL_W'(r_s6_t);
            r_s7_d1 <= r_s6_d1;
            r_s7_d0 <= r_s6_d0;
            r_s7_t  <= r_s6_t;
        end
        if (en[8]) begin
            r_s8_hi <= n_s8_hi;
            r_s8_lo <= q2[FRAC_W-1:0];
            r_s8_d0 <= r_s7_d0;
            r_s8_t  <= r_s7_t;
        end
        if (en[9]) begin
            r_s9_ph <= r_s8_hi * $signed({1'b0, r_s8_t});
            r_s9_pl <= PL_W'(r_s8_lo) * PL_W'(r_s8_t);
            r_s9_d0 <= r_s8_d0;
        end
        if (en[10]) begin
            // the result stays far inside the output range, no clipping needed
            r_s10_curve <= few ? '0 : CURVE_W'(hi3 >>> 1);
            r_s10_few   <= few;
        end
    end

    assign o_m_tvalid = r_v[NSTG];
    assign o_m_tdata  = r_s10_curve;
    assign o_m_tuser  = r_s10_few;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `ASSERT_CLK(a_empty_out_ready, !o_m_tvalid |-> o_s_tready, "input blocked with empty output")
    `ASSERT_CLK(a_span_in_range, (r_v[2] && r_s2_cmd == CMD_EVAL && !few) |-> ({3'b0, r_s2_span} + 9'd3 < 9'(n_eff)), "span reads past knot count")
    `ASSERT_CLK(a_frac_in_range, (r_v[2] && r_s2_cmd == CMD_EVAL) |-> (r_s2_t <= P_ONE), "span fraction above one")
    `ASSERT_CLK(a_few_zero, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0), "error result with nonzero value")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// catmull-rom spline evaluator testbench
// drives knot loads and spline evaluations through the request stream, keeps
// a shadow knot table and count, predicts each curve value or takes a typed one, in order, and
// compares it with the result stream under random idling and back-pressure
// ----------------------------------------------------------------------------
module testbench;
    import crse_pkg::*;

    localparam int MAX_KNOTS       = 32;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int DRAIN_CYCLES    = 16;
    localparam int LONG_STALL      = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int NUM_DIRECTED    = 21;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_EVAL,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic [CURVE_W-1:0] curve;
        logic               flag;
    } curve_result_t;

    typedef struct {
        row_kind_t                 kind;
        logic [IDX_W-1:0]          idx;
        logic signed [KNOT_W-1:0]  val;
        logic signed [POS_W-1:0]   pos;
        logic [CNT_W-1:0]          cnt;
        bit                        fixed;
        curve_result_t             result;
    } stim_row_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CNT_W-1:0]         i_cfg_data;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    // knot_index[4:0], knot_value[20:5], position[44:21], zero pad
    logic [IN_TDATA_W-1:0]    i_s_tdata;
    // cmd[0]
    logic                     i_s_tuser;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    // curve_value[23:0]
    logic [OUT_TDATA_W-1:0]   o_m_tdata;
    // too_few_knots[0]
    logic                     o_m_tuser;

    logic signed [KNOT_W-1:0] knot_shadow [MAX_KNOTS];
    logic [CNT_W-1:0]         shadow_count;
    curve_result_t            pending_curves [$];
    curve_result_t            head;
    int                       errors;
    int                       stalled;
    int                       long_stall_req;
    int                       long_stall_done;
    bit                       idle_on;

    // typed results: position 0 gives knot 1, position 1.0 gives knot 2
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{ROW_LOAD, 5'd0,  -16'sd32768, 24'sd0,        6'd0, 1'b0, '0},
        '{ROW_LOAD, 5'd1,   16'sd32767, 24'sd0,        6'd0, 1'b0, '0},
        '{ROW_LOAD, 5'd2,  -16'sd32768, 24'sd0,        6'd0, 1'b0, '0},
        '{ROW_LOAD, 5'd3,   16'sd32767, 24'sd0,        6'd0, 1'b0, '0},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd0,        6'd0, 1'b1, {24'sd32767, 1'b0}},
        '{ROW_EVAL, 5'd0,   16'sd0,    -24'sd8388608,  6'd0, 1'b1, {24'sd32767, 1'b0}},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd65536,    6'd0, 1'b1, {-24'sd32768, 1'b0}},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd8388607,  6'd0, 1'b1, {-24'sd32768, 1'b0}},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd32768,    6'd0, 1'b0, '0},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd1,        6'd0, 1'b0, '0},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd65535,    6'd0, 1'b0, '0},
        '{ROW_LOAD, 5'd31,  16'sh5A5A,  24'sd0,        6'd0, 1'b0, '0},
        '{ROW_LOAD, 5'd0,   16'sd0,     24'sd0,        6'd0, 1'b0, '0},
        '{ROW_LOAD, 5'd3,  -16'sd1,     24'sd0,        6'd0, 1'b0, '0},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd16384,    6'd0, 1'b0, '0},
        '{ROW_CFG,  5'd0,   16'sd0,     24'sd0,        6'd0, 1'b0, '0},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd20000,    6'd0, 1'b1, {24'sd0, 1'b1}},
        '{ROW_CFG,  5'd0,   16'sd0,     24'sd0,        6'd3, 1'b0, '0},
        '{ROW_EVAL, 5'd0,   16'sd0,    -24'sd5,        6'd0, 1'b1, {24'sd0, 1'b1}},
        '{ROW_CFG,  5'd0,   16'sd0,     24'sd0,        6'd4, 1'b0, '0},
        '{ROW_EVAL, 5'd0,   16'sd0,     24'sd49152,    6'd0, 1'b0, '0}
    };

    catmull_rom_spline_eval #(
        .MAX_KNOTS (MAX_KNOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic curve_result_t predict_curve(input logic signed [POS_W-1:0] pos);
        curve_result_t res;
        longint n, p, s, span, t;
        longint k0, k1, k2, k3, d3, d2, d1, d0, acc, r;
        n = (shadow_count > MAX_KNOTS) ? MAX_KNOTS : shadow_count;
        if (n < MIN_KNOTS) begin
            res.curve = '0;
            res.flag  = 1'b1;
            return res;
        end
        p = pos;
        if (p < 0)
            p = 0;
        if (p > 65536)
            p = 65536;
        s = p * (n - 3);
        span = s >>> FRAC_W;
        if (span > n - 4)
            span = n - 4;
        t = s - span * 65536;
        k0 = knot_shadow[span];
        k1 = knot_shadow[span + 1];
        k2 = knot_shadow[span + 2];
        k3 = knot_shadow[span + 3];
        // basis coefficients, doubled to stay integer
        d3 = -k0 + 3 * k1 - 3 * k2 + k3;
        d2 = 2 * k0 - 5 * k1 + 4 * k2 - k3;
        d1 = k2 - k0;
        d0 = 2 * k1;
        acc = d3 * 65536;
        acc = ((acc * t) >>> FRAC_W) + d2 * 65536;
        acc = ((acc * t) >>> FRAC_W) + d1 * 65536;
        acc = ((acc * t) >>> FRAC_W) + d0 * 65536;
        // halve and round half up to an integer with no fraction bits
        r = (acc + 65536) >>> 17;
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        res.curve = r[CURVE_W-1:0];
        res.flag  = 1'b0;
        return res;
    endfunction

    task automatic send_req(input t_cmd cmd, input logic [IN_TDATA_W-1:0] data,
                            input bit fixed, input curve_result_t fixed_res);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (cmd == CMD_LOAD)
            knot_shadow[data[IDX_W-1:0]] = data[IDX_W+KNOT_W-1:IDX_W];
        else if (fixed)
            pending_curves.push_back(fixed_res);
        else
            pending_curves.push_back(predict_curve(data[IDX_W+KNOT_W+POS_W-1:IDX_W+KNOT_W]));
    endtask

    // knot count only changes once the pipeline has drained
    task automatic write_count(input logic [CNT_W-1:0] cnt);
        i_s_tvalid <= 1'b0;
        while (pending_curves.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cnt;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        shadow_count = cnt;
    endtask

    // result side ready, with idle bursts and one long hold-off on request
    initial begin
        i_m_tready <= 1'b0;
        long_stall_done = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_stall_req != long_stall_done) begin
                i_m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                long_stall_done = long_stall_done + 1;
                i_m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_curves.size() == 0) begin
                $error("unexpected result: curve_value %0d too_few_knots %0d",
                       $signed(o_m_tdata), o_m_tuser);
                errors = errors + 1;
            end else begin
                head = pending_curves.pop_front();
                if (o_m_tdata !== head.curve) begin
                    $error("curve_value expected %0d actual %0d",
                           $signed(head.curve), $signed(o_m_tdata));
                    errors = errors + 1;
                end
                if (o_m_tuser !== head.flag) begin
                    $error("too_few_knots expected %0d actual %0d", head.flag, o_m_tuser);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_cfg_valid && o_cfg_ready))
                stalled = 0;
            else
                stalled = stalled + 1;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        stim_row_t                row;
        logic [CNT_W-1:0]         cnt;
        logic [IDX_W-1:0]         rnd_idx;
        logic signed [KNOT_W-1:0] rnd_val;
        logic signed [POS_W-1:0]  rnd_pos;
        int                       n_eff;
        int                       spans;
        int                       k;
        int                       pick;
        errors         = 0;
        long_stall_req = 0;
        idle_on        = 1'b1;
        shadow_count   = 6'd4;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= CMD_LOAD;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            case (row.kind)
                ROW_CFG: begin
                    write_count(row.cnt);
                end
                ROW_LOAD: begin
                    send_req(CMD_LOAD, {3'b000, 24'd0, row.val, row.idx}, 1'b0, '0);
                end
                default: begin
                    send_req(CMD_EVAL, {3'b000, row.pos, 16'd0, 5'd0}, row.fixed, row.result);
                end
            endcase
        end

        // every entry written before any count can reach it
        for (int i = 0; i < MAX_KNOTS; i++) begin
            rnd_val = $urandom;
            rnd_pos = $urandom;
            send_req(CMD_LOAD, {3'b000, rnd_pos, rnd_val, 5'(i)}, 1'b0, '0);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: cnt = 6'd63;
                1: cnt = 6'd32;
                2: cnt = 6'd4;
                3: cnt = 6'd33;
                4: cnt = 6'd5;
                5: cnt = 6'd0;
                6: cnt = 6'd3;
                7: cnt = 6'd1;
                8: cnt = 6'd31;
                9: cnt = 6'd17;
                default: cnt = $urandom_range(0, 63);
            endcase
            write_count(cnt);
            idle_on = ($urandom_range(0, 3) != 0) && (ph < NUM_PHASES - 2);
            // hold the result side off while requests keep coming
            if (ph == 1)
                long_stall_req = long_stall_req + 1;
            n_eff = (shadow_count > MAX_KNOTS) ? MAX_KNOTS : shadow_count;
            spans = n_eff - 3;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                rnd_idx = $urandom;
                rnd_val = $urandom;
                rnd_pos = $urandom;
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 7))
                        0: rnd_val = 16'sh7FFF;
                        1: rnd_val = 16'sh8000;
                        default: ;
                    endcase
                    send_req(CMD_LOAD, {3'b000, rnd_pos, rnd_val, rnd_idx}, 1'b0, '0);
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick == 1) begin
                        case ($urandom_range(0, 3))
                            0: rnd_pos = 24'sd0;
                            1: rnd_pos = 24'sd65536;
                            2: rnd_pos = -24'sd1 - 24'($urandom_range(0, 8388607));
                            default: rnd_pos = 24'($urandom_range(65537, 8388607));
                        endcase
                    end else if (pick == 2 && spans > 0) begin
                        // land near a span boundary
                        k = $urandom_range(0, spans);
                        rnd_pos = 24'((k * 65536 + spans - 1) / spans + $urandom_range(0, 2) - 1);
                    end else if (pick != 0) begin
                        rnd_pos = 24'($urandom_range(0, 65536));
                    end
                    send_req(CMD_EVAL, {3'b000, rnd_pos, rnd_val, rnd_idx}, 1'b0, '0);
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_curves.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_curves.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/crse_pkg.sv
hw/rtl/crse_ram.sv
hw/rtl/catmull_rom_spline_eval.sv
dv/testbench.sv
